// ===== rtl/core/lrss_pkg.sv =====
// ----------------------------------------------------------------------------
// lrss_pkg
// Shared constants and types for the log record scan summary block.
// ----------------------------------------------------------------------------
package lrss_pkg;

  localparam int unsigned AREA_BYTES   = 65536;
  localparam int unsigned RECORD_BYTES = 32;
  localparam int unsigned ADDR_W       = 16;
  localparam int unsigned WORD_W       = 32;
  localparam int unsigned CODE_W       = 16;

  localparam logic [WORD_W-1:0] MAGIC_VALUE = 32'h4C4F_4735;
  localparam logic [WORD_W-1:0] CHECK_SALT  = 32'hA5A5_5A5A;

  // One log record slot as it travels through the input register.
  typedef struct packed {
    logic              first_of_scan;
    logic [ADDR_W-1:0] record_address;
    logic [WORD_W-1:0] magic_word;
    logic [WORD_W-1:0] sequence_word;
    logic [WORD_W-1:0] time_word;
    logic [CODE_W-1:0] event_code;
    logic [CODE_W-1:0] event_param;
    logic [WORD_W-1:0] detail_word;
    logic [WORD_W-1:0] extra_word;
    logic [WORD_W-1:0] check_word;
    logic [WORD_W-1:0] reserved_word;
  } rec_t;

  // Running summary carried by one result beat.
  typedef struct packed {
    logic              record_valid;
    logic [WORD_W-1:0] latest_sequence_out;
    logic [ADDR_W-1:0] next_write_address;
    logic [WORD_W-1:0] next_sequence_out;
    logic [WORD_W-1:0] latest_clear_sequence_out;
  } sum_t;

endpackage

// ===== rtl/core/lrss_rec_if.sv =====
// ----------------------------------------------------------------------------
// lrss_rec_if
// Record channel: one log record slot per beat.
// ----------------------------------------------------------------------------
interface lrss_rec_if
  import lrss_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              first_of_scan;
  logic [ADDR_W-1:0] record_address;
  logic [WORD_W-1:0] magic_word;
  logic [WORD_W-1:0] sequence_word;
  logic [WORD_W-1:0] time_word;
  logic [CODE_W-1:0] event_code;
  logic [CODE_W-1:0] event_param;
  logic [WORD_W-1:0] detail_word;
  logic [WORD_W-1:0] extra_word;
  logic [WORD_W-1:0] check_word;
  logic [WORD_W-1:0] reserved_word;

  modport source (
    output valid, first_of_scan, record_address, magic_word, sequence_word,
           time_word, event_code, event_param, detail_word, extra_word,
           check_word, reserved_word,
    input  ready
  );

  modport sink (
    input  valid, first_of_scan, record_address, magic_word, sequence_word,
           time_word, event_code, event_param, detail_word, extra_word,
           check_word, reserved_word,
    output ready
  );
endinterface

// ===== rtl/core/lrss_sum_if.sv =====
// ----------------------------------------------------------------------------
// lrss_sum_if
// Summary channel: validity and running scan summary per beat.
// ----------------------------------------------------------------------------
interface lrss_sum_if
  import lrss_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              record_valid;
  logic [WORD_W-1:0] latest_sequence_out;
  logic [ADDR_W-1:0] next_write_address;
  logic [WORD_W-1:0] next_sequence_out;
  logic [WORD_W-1:0] latest_clear_sequence_out;

  modport source (
    output valid, record_valid, latest_sequence_out, next_write_address,
           next_sequence_out, latest_clear_sequence_out,
    input  ready
  );

  modport sink (
    input  valid, record_valid, latest_sequence_out, next_write_address,
           next_sequence_out, latest_clear_sequence_out,
    output ready
  );
endinterface

// ===== rtl/core/lrss_check.sv =====
// ----------------------------------------------------------------------------
// lrss_check
// Record integrity test: magic word match and XOR check word match.
// ----------------------------------------------------------------------------
module lrss_check
  import lrss_pkg::*;
(
  input  rec_t rec_i,
  output logic ok_o
);

  logic [WORD_W-1:0] sum;

  assign sum = rec_i.magic_word
             ^ rec_i.sequence_word
             ^ rec_i.time_word
             ^ {rec_i.event_code, {(WORD_W-CODE_W){1'b0}}}
             ^ {{(WORD_W-CODE_W){1'b0}}, rec_i.event_param}
             ^ rec_i.detail_word
             ^ rec_i.extra_word
             ^ rec_i.reserved_word
             ^ CHECK_SALT;

  assign ok_o = (rec_i.magic_word == MAGIC_VALUE) && (rec_i.check_word == sum);

endmodule

// ===== rtl/core/log_record_scan_summary_core.sv =====
// ----------------------------------------------------------------------------
// log_record_scan_summary_core
// Scans flash log records one per beat and keeps the running summary:
// latest sequence, next write address and latest log-cleared sequence.
// ----------------------------------------------------------------------------
// Path: an accepted record beat goes to the input register, then to the result
//   register; it is held back only while the sink stalls.
// Throughput: one record per cycle while the sink does not stall, set by the
//   combinational summary update between the input and result registers.
// Reset: rst_ni low clears both valid flags, the summary state and the
//   log-cleared event code asynchronously.
module log_record_scan_summary_core
  import lrss_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CODE_W-1:0] cfg_wdata_i,
  lrss_rec_if.sink          rec_i,
  lrss_sum_if.source        sum_o
);

  // Configuration: event id of a log-cleared record.
  logic [CODE_W-1:0] clr_code_q;

  // Input register.
  logic in_vld_q, in_vld_d;
  rec_t rec_q;
  rec_t rec_in;

  // Result register.
  logic out_vld_q, out_vld_d;
  sum_t sum_q, sum_d;

  // Summary state.
  logic [WORD_W-1:0] latest_q, latest_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [WORD_W-1:0] clr_seq_q, clr_seq_d;

  logic              in_acc;
  logic              adv;
  logic              rec_ok;
  logic [WORD_W-1:0] base_latest;
  logic [ADDR_W-1:0] base_addr;
  logic [WORD_W-1:0] base_clr;
  logic [ADDR_W:0]   addr_sum;
  logic              addr_wrap;

  // Advance the held record whenever the result register is free or drains now.
  assign adv       = in_vld_q && (!out_vld_q || sum_o.ready);
  assign rec_i.ready = !in_vld_q || adv;
  assign in_acc    = rec_i.valid && rec_i.ready;

  assign rec_in = '{
    first_of_scan:  rec_i.first_of_scan,
    record_address: rec_i.record_address,
    magic_word:     rec_i.magic_word,
    sequence_word:  rec_i.sequence_word,
    time_word:      rec_i.time_word,
    event_code:     rec_i.event_code,
    event_param:    rec_i.event_param,
    detail_word:    rec_i.detail_word,
    extra_word:     rec_i.extra_word,
    check_word:     rec_i.check_word,
    reserved_word:  rec_i.reserved_word
  };

  lrss_check u_check (
    .rec_i (rec_q),
    .ok_o  (rec_ok)
  );

  // Drop the summary to zero first when this record opens a new scan.
  assign base_latest = rec_q.first_of_scan ? '0 : latest_q;
  assign base_addr   = rec_q.first_of_scan ? '0 : addr_q;
  assign base_clr    = rec_q.first_of_scan ? '0 : clr_seq_q;

  // Address just past the record; wrap to zero at or beyond the area end.
  assign addr_sum  = {1'b0, rec_q.record_address} + (ADDR_W+1)'(RECORD_BYTES);
  assign addr_wrap = 32'(addr_sum) >= 32'(AREA_BYTES);

  always_comb begin
    latest_d  = base_latest;
    addr_d    = base_addr;
    clr_seq_d = base_clr;
    if (rec_ok) begin
      // An equal sequence still moves the write address on.
      if (rec_q.sequence_word >= base_latest) begin
        latest_d = rec_q.sequence_word;
        addr_d   = addr_wrap ? '0 : addr_sum[ADDR_W-1:0];
      end
      if ((rec_q.event_code == clr_code_q) && (rec_q.sequence_word > base_clr)) begin
        clr_seq_d = rec_q.sequence_word;
      end
    end
  end

  always_comb begin
    sum_d.record_valid              = rec_ok;
    sum_d.latest_sequence_out       = latest_d;
    sum_d.next_write_address        = addr_d;
    sum_d.next_sequence_out         = (latest_d != '0) ? latest_d + WORD_W'(1) : WORD_W'(1);
    sum_d.latest_clear_sequence_out = clr_seq_d;
  end

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_acc) begin
      in_vld_d = 1'b1;
    end else if (adv) begin
      in_vld_d = 1'b0;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (adv) begin
      out_vld_d = 1'b1;
    end else if (sum_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_code_q <= '0;
      in_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
      latest_q   <= '0;
      addr_q     <= '0;
      clr_seq_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        clr_code_q <= cfg_wdata_i;
      end
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (adv) begin
        latest_q  <= latest_d;
        addr_q    <= addr_d;
        clr_seq_q <= clr_seq_d;
      end
    end
  end

  // Payload registers: record on an accepted beat, summary on an advance; hold otherwise.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rec_q <= rec_in;
    end
    if (adv) begin
      sum_q <= sum_d;
    end
  end

  assign sum_o.valid                     = out_vld_q;
  assign sum_o.record_valid              = sum_q.record_valid;
  assign sum_o.latest_sequence_out       = sum_q.latest_sequence_out;
  assign sum_o.next_write_address        = sum_q.next_write_address;
  assign sum_o.next_sequence_out         = sum_q.next_sequence_out;
  assign sum_o.latest_clear_sequence_out = sum_q.latest_clear_sequence_out;

endmodule

// ===== rtl/core/lrss_sva.sv =====
// ----------------------------------------------------------------------------
// lrss_sva
// Port-level checks on the summary channel, bound to the top level.
// ----------------------------------------------------------------------------
module lrss_sva
  import lrss_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic              record_valid_i,
  input logic [WORD_W-1:0] latest_i,
  input logic [ADDR_W-1:0] next_addr_i,
  input logic [WORD_W-1:0] next_seq_i,
  input logic [WORD_W-1:0] latest_clr_i
);

  // A stalled summary beat holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(record_valid_i)
      && $stable(latest_i) && $stable(next_addr_i) && $stable(next_seq_i)
      && $stable(latest_clr_i))
    else $error("summary beat changed while stalled");

  // Next sequence follows the latest sequence.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> next_seq_i ==
      ((latest_i != '0) ? latest_i + WORD_W'(1) : WORD_W'(1)))
    else $error("next sequence does not follow latest sequence");

  // Write address stays inside the log area.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> 32'(next_addr_i) < 32'(AREA_BYTES))
    else $error("next write address beyond area end");

  // No summary beat shows while reset is asserted.
  assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("summary beat during reset");

endmodule

bind log_record_scan_summary_core lrss_sva u_lrss_sva (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (sum_o.valid),
  .out_ready_i    (sum_o.ready),
  .record_valid_i (sum_o.record_valid),
  .latest_i       (sum_o.latest_sequence_out),
  .next_addr_i    (sum_o.next_write_address),
  .next_seq_i     (sum_o.next_sequence_out),
  .latest_clr_i   (sum_o.latest_clear_sequence_out)
);
